// ===== hw/rtl/http_request_head_parser_defines.svh =====
// ----------------------------------------------------------------------------
// http_request_head_parser_defines.svh
// Assertion macros shared by the parser's checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and character classes for the HTTP request head parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

    // Grammar position
    typedef enum logic [4:0] {
        PS_START     = 5'd0,
        PS_METHOD    = 5'd1,
        PS_TARGET    = 5'd2,
        PS_LIT_H     = 5'd3,
        PS_LIT_T0    = 5'd4,
        PS_LIT_T1    = 5'd5,
        PS_LIT_P     = 5'd6,
        PS_LIT_SLASH = 5'd7,
        PS_MAJOR     = 5'd8,
        PS_DOT       = 5'd9,
        PS_MINOR     = 5'd10,
        PS_RL_CR     = 5'd11,
        PS_RL_LF     = 5'd12,
        PS_LINE      = 5'd13,
        PS_NAME      = 5'd14,
        PS_VALUE     = 5'd15,
        PS_LINE_LF   = 5'd16,
        PS_END_LF    = 5'd17
    } t_pstate;

    // Status codes
    localparam logic [1:0] STAT_CONT = 2'd0;
    localparam logic [1:0] STAT_PASS = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    // Token kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_TARGET = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;
    localparam logic [2:0] KIND_VALUE  = 3'd4;
    localparam logic [2:0] KIND_MAJOR  = 3'd5;
    localparam logic [2:0] KIND_MINOR  = 3'd6;

    // Held blank codes
    localparam logic [1:0] BLANK_NONE = 2'd0;
    localparam logic [1:0] BLANK_SP   = 2'd1;
    localparam logic [1:0] BLANK_TAB  = 2'd2;

    // Characters
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // One result beat
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       token_end;
        logic [1:0] blank_before;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_token_char(input logic [7:0] c);
        logic r;
        r = is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        unique case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
            8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C,
            8'h7E: r = 1'b1;
            default: r = r;
        endcase
        return r;
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return (c < 8'h20) || (c == CH_DEL);
    endfunction

    function automatic logic is_value_char(input logic [7:0] c);
        return ((c >= 8'h21) && (c <= 8'h7E)) || c[7];
    endfunction

endpackage

// ===== hw/rtl/hrp_if.sv =====
// ----------------------------------------------------------------------------
// hrp_in_if / hrp_out_if
// Valid/ready channels for request bytes in and parse results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       restart;

    modport source (output valid, output byte_in, output restart, input ready);
    modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface hrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       token_end;
    logic [1:0] blank_before;

    modport source (output valid, output status, output kind, output data_byte,
                    output token_end, output blank_before, input ready);
    modport sink   (input valid, input status, input kind, input data_byte,
                    input token_end, input blank_before, output ready);
endinterface

// ===== hw/rtl/http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-at-a-time HTTP request head checker and tokenizer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents
//  -------  ---  -----------------------------------------------------------
//  i_req    in   byte_in[7:0], restart
//  o_res    out  status[1:0], kind[2:0], data_byte[7:0], token_end,
//                blank_before[1:0]
//
// One byte per clock sustained while o_res keeps taking results; every
// accepted byte yields one result beat. The grammar step is a single
// state update feeding the result register, or the skid entry under stall.
// Reset (i_rst_n low, synchronous) clears the grammar state, the held blank
// and both result slots; the parser starts at the request line.
// A two-entry result buffer (output register plus skid) lets input keep
// flowing for one beat while o_res is stalled; i_req.ready drops only when
// both entries are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_head_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrp_in_if.sink    i_req,
    hrp_out_if.source o_res
);
    import hrp_pkg::*;

    // Parser state
    t_pstate    r_state, n_state;
    logic [1:0] r_pend,  n_pend;     // held inner blank of a value
    logic       r_started, n_started; // first value byte seen
    logic [1:0] r_final, n_final;    // sticky pass / fail

    // State as seen by this beat (restart wins over stored state)
    t_pstate    w_cur_state;
    logic [1:0] w_cur_pend;
    logic       w_cur_started;
    logic [1:0] w_cur_final;

    t_result    w_res;
    logic       w_accept;

    // Result buffer
    t_result    r_out, r_skid;
    logic       r_out_valid, r_skid_valid;

    assign i_req.ready = !r_skid_valid;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_cur_state   = i_req.restart ? PS_START   : r_state;
    assign w_cur_pend    = i_req.restart ? BLANK_NONE : r_pend;
    assign w_cur_started = i_req.restart ? 1'b0       : r_started;
    assign w_cur_final   = i_req.restart ? STAT_CONT  : r_final;

    // ---- state register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_START;
            r_pend    <= BLANK_NONE;
            r_started <= 1'b0;
            r_final   <= STAT_CONT;
        end else if (w_accept) begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_started <= n_started;
            r_final   <= n_final;
        end
    end

    // ---- grammar step: next state and result for the current byte ----
    always_comb begin
        logic [7:0] c;
        logic       fail;
        logic       pass;

        c         = i_req.byte_in;
        fail      = 1'b0;
        pass      = 1'b0;
        n_state   = w_cur_state;
        n_pend    = w_cur_pend;
        n_started = w_cur_started;
        n_final   = w_cur_final;
        w_res     = '0;

        if (w_cur_final != STAT_CONT) begin
            // Finished: status repeats until restart
            w_res.status = w_cur_final;
        end else begin
            unique case (w_cur_state)
                PS_START: begin
                    if (is_token_char(c)) begin
                        w_res.kind      = KIND_METHOD;
                        w_res.data_byte = c;
                        n_state         = PS_METHOD;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_METHOD: begin
                    if (c == CH_SP) begin
                        w_res.kind      = KIND_METHOD;
                        w_res.token_end = 1'b1;
                        n_state         = PS_TARGET;
                    end else if (is_token_char(c)) begin
                        w_res.kind      = KIND_METHOD;
                        w_res.data_byte = c;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_TARGET: begin
                    if (c == CH_SP) begin
                        w_res.kind      = KIND_TARGET;
                        w_res.token_end = 1'b1;
                        n_state         = PS_LIT_H;
                    end else if (!is_ctl(c)) begin
                        w_res.kind      = KIND_TARGET;
                        w_res.data_byte = c;
                    end else begin
                        fail = 1'b1;
                    end
                end
                // Literal "HTTP/" and the dot: checked, nothing reported
                PS_LIT_H: begin
                    if (c == CH_H) n_state = PS_LIT_T0; else fail = 1'b1;
                end
                PS_LIT_T0: begin
                    if (c == CH_T) n_state = PS_LIT_T1; else fail = 1'b1;
                end
                PS_LIT_T1: begin
                    if (c == CH_T) n_state = PS_LIT_P; else fail = 1'b1;
                end
                PS_LIT_P: begin
                    if (c == CH_P) n_state = PS_LIT_SLASH; else fail = 1'b1;
                end
                PS_LIT_SLASH: begin
                    if (c == CH_SLASH) n_state = PS_MAJOR; else fail = 1'b1;
                end
                PS_MAJOR: begin
                    if (is_digit(c)) begin
                        w_res.kind      = KIND_MAJOR;
                        w_res.data_byte = c - CH_0;
                        w_res.token_end = 1'b1;
                        n_state         = PS_DOT;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_DOT: begin
                    if (c == CH_DOT) n_state = PS_MINOR; else fail = 1'b1;
                end
                PS_MINOR: begin
                    if (is_digit(c)) begin
                        w_res.kind      = KIND_MINOR;
                        w_res.data_byte = c - CH_0;
                        w_res.token_end = 1'b1;
                        n_state         = PS_RL_CR;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_RL_CR: begin
                    if (c == CH_CR) n_state = PS_RL_LF; else fail = 1'b1;
                end
                PS_RL_LF: begin
                    if (c == CH_LF) n_state = PS_LINE; else fail = 1'b1;
                end
                PS_LINE: begin
                    // CR here starts the empty line that ends the head
                    if (c == CH_CR) begin
                        n_state = PS_END_LF;
                    end else if (is_token_char(c)) begin
                        w_res.kind      = KIND_NAME;
                        w_res.data_byte = c;
                        n_state         = PS_NAME;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_NAME: begin
                    if (c == CH_COLON) begin
                        w_res.kind      = KIND_NAME;
                        w_res.token_end = 1'b1;
                        n_pend          = BLANK_NONE;
                        n_started       = 1'b0;
                        n_state         = PS_VALUE;
                    end else if (is_token_char(c)) begin
                        w_res.kind      = KIND_NAME;
                        w_res.data_byte = c;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_VALUE: begin
                    if (c == CH_CR) begin
                        // trailing held blank is dropped
                        w_res.kind      = KIND_VALUE;
                        w_res.token_end = 1'b1;
                        n_pend          = BLANK_NONE;
                        n_started       = 1'b0;
                        n_state         = PS_LINE_LF;
                    end else if (is_value_char(c)) begin
                        w_res.kind         = KIND_VALUE;
                        w_res.data_byte    = c;
                        w_res.blank_before = w_cur_pend;
                        n_pend             = BLANK_NONE;
                        n_started          = 1'b1;
                    end else if (c == CH_SP || c == CH_TAB) begin
                        // leading blanks skipped; inner run keeps its first blank
                        if (w_cur_started && w_cur_pend == BLANK_NONE) begin
                            n_pend = (c == CH_SP) ? BLANK_SP : BLANK_TAB;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                PS_LINE_LF: begin
                    if (c == CH_LF) n_state = PS_LINE; else fail = 1'b1;
                end
                PS_END_LF: begin
                    if (c == CH_LF) pass = 1'b1; else fail = 1'b1;
                end
                default: begin
                    fail = 1'b1;
                end
            endcase

            if (fail || pass) begin
                n_final = fail ? STAT_FAIL : STAT_PASS;
                w_res   = '0;
            end
            w_res.status = n_final;
        end
    end

    // ---- result buffer: output register with one skid entry ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || o_res.ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_res.ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.kind         = r_out.kind;
    assign o_res.data_byte    = r_out.data_byte;
    assign o_res.token_end    = r_out.token_end;
    assign o_res.blank_before = r_out.blank_before;

endmodule

// ===== hw/rtl/hrp_checker.sv =====
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks for the HTTP request head parser, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_head_parser_defines.svh"

module hrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [2:0] i_kind,
    input logic [7:0] i_data_byte,
    input logic       i_token_end,
    input logic [1:0] i_blank_before
);
    import hrp_pkg::*;

    // Input only backs up when a result is waiting
    `HRP_ASSERT_NOW(a_ready_low_needs_result, !i_in_ready, i_out_valid, "input stalled with no result pending")

    // Stalled result beat holds
    `HRP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_status, i_kind, i_data_byte, i_token_end, i_blank_before}), "result changed while stalled")

    // Pass or fail beats carry nothing else
    `HRP_ASSERT_NOW(a_final_clean, i_out_valid && i_status != STAT_CONT, i_kind == KIND_NONE && i_data_byte == 8'd0 && !i_token_end && i_blank_before == BLANK_NONE, "final status with payload")

    // Version digits are whole tokens with values 0..9
    `HRP_ASSERT_NOW(a_digit_token, i_out_valid && (i_kind == KIND_MAJOR || i_kind == KIND_MINOR), i_token_end && i_data_byte <= 8'd9, "bad version digit beat")

    // Held blanks only travel with value bytes
    `HRP_ASSERT_NOW(a_blank_in_value, i_out_valid && i_blank_before != BLANK_NONE, i_kind == KIND_VALUE && !i_token_end, "held blank outside value data")

endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_kind         (o_res.kind),
    .i_data_byte    (o_res.data_byte),
    .i_token_end    (o_res.token_end),
    .i_blank_before (o_res.blank_before)
);

// ===== bench/tb_http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// tb_http_request_head_parser
// Self-checking bench for the byte-serial HTTP request head parser. A local
// grammar tracker predicts the result beat of every accepted request byte;
// each result beat is checked field by field against the oldest prediction.
// Stimulus: a directed request, sticky pass/fail checks, then random
// well-formed, damaged and cut-short requests plus raw noise, with random
// gaps on both channels and one stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_request_head_parser;
    import hrp_pkg::*;

    typedef logic [7:0] t_bytes[$];

    // Generous bound: under 1000 request beats, with random gaps and stalls.
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PCT     = 26;
    localparam int MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;

    hrp_in_if  req_if ();
    hrp_out_if res_if ();

    http_request_head_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // Local copy of the parser state, advanced once per accepted byte.
    // ------------------------------------------------------------------------
    t_pstate    head_pos;
    logic [1:0] held_blank;    // collapsed inner blank waiting for next data
    logic       value_seen;    // a value byte arrived in the current field
    logic [1:0] head_status;   // sticky pass/fail

    t_result    pending_results[$];
    int         mismatches;
    int         cycle_count;
    int         items_sent;
    bit         no_gaps;       // full-rate stretch: both sides run without idling

    // RFC token characters: alphanumerics plus a fixed set of punctuation.
    function automatic logic tchar(input logic [7:0] c);
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A))
            return 1'b1;
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Visible value bytes: printable ASCII without space, and all of 0x80..0xFF.
    function automatic logic vchar(input logic [7:0] c);
        return (c >= 8'h21 && c != CH_DEL) ? 1'b1 : 1'b0;
    endfunction

    function automatic t_result step_head(input logic [7:0] c, input logic rs);
        t_result r;
        logic    bad;
        logic    done;
        r    = '0;
        bad  = 1'b0;
        done = 1'b0;
        if (rs) begin
            head_pos    = PS_START;
            held_blank  = BLANK_NONE;
            value_seen  = 1'b0;
            head_status = STAT_CONT;
        end
        // Once the head has passed or failed, only the status is reported.
        if (head_status != STAT_CONT) begin
            r.status = head_status;
            return r;
        end
        case (head_pos)
            PS_START: begin
                if (tchar(c)) begin
                    r.kind = KIND_METHOD; r.data_byte = c; head_pos = PS_METHOD;
                end else bad = 1'b1;
            end
            PS_METHOD: begin
                if (c == CH_SP) begin
                    r.kind = KIND_METHOD; r.token_end = 1'b1; head_pos = PS_TARGET;
                end else if (tchar(c)) begin
                    r.kind = KIND_METHOD; r.data_byte = c;
                end else bad = 1'b1;
            end
            PS_TARGET: begin
                if (c == CH_SP) begin
                    r.kind = KIND_TARGET; r.token_end = 1'b1; head_pos = PS_LIT_H;
                end else if (c >= 8'h20 && c != CH_DEL) begin
                    r.kind = KIND_TARGET; r.data_byte = c;
                end else bad = 1'b1;
            end
            // "HTTP/" literal: consumed silently
            PS_LIT_H:     if (c == CH_H) head_pos = PS_LIT_T0; else bad = 1'b1;
            PS_LIT_T0:    if (c == CH_T) head_pos = PS_LIT_T1; else bad = 1'b1;
            PS_LIT_T1:    if (c == CH_T) head_pos = PS_LIT_P; else bad = 1'b1;
            PS_LIT_P:     if (c == CH_P) head_pos = PS_LIT_SLASH; else bad = 1'b1;
            PS_LIT_SLASH: if (c == CH_SLASH) head_pos = PS_MAJOR; else bad = 1'b1;
            PS_MAJOR: begin
                if (c >= CH_0 && c <= CH_9) begin
                    r.kind = KIND_MAJOR; r.data_byte = c - CH_0; r.token_end = 1'b1;
                    head_pos = PS_DOT;
                end else bad = 1'b1;
            end
            PS_DOT: if (c == CH_DOT) head_pos = PS_MINOR; else bad = 1'b1;
            PS_MINOR: begin
                if (c >= CH_0 && c <= CH_9) begin
                    r.kind = KIND_MINOR; r.data_byte = c - CH_0; r.token_end = 1'b1;
                    head_pos = PS_RL_CR;
                end else bad = 1'b1;
            end
            PS_RL_CR: if (c == CH_CR) head_pos = PS_RL_LF; else bad = 1'b1;
            PS_RL_LF: if (c == CH_LF) head_pos = PS_LINE; else bad = 1'b1;
            PS_LINE: begin
                if (c == CH_CR) head_pos = PS_END_LF;
                else if (tchar(c)) begin
                    r.kind = KIND_NAME; r.data_byte = c; head_pos = PS_NAME;
                end else bad = 1'b1;
            end
            PS_NAME: begin
                if (c == CH_COLON) begin
                    r.kind = KIND_NAME; r.token_end = 1'b1;
                    held_blank = BLANK_NONE; value_seen = 1'b0;
                    head_pos = PS_VALUE;
                end else if (tchar(c)) begin
                    r.kind = KIND_NAME; r.data_byte = c;
                end else bad = 1'b1;
            end
            PS_VALUE: begin
                if (c == CH_CR) begin
                    // trailing held blank is dropped here
                    r.kind = KIND_VALUE; r.token_end = 1'b1;
                    held_blank = BLANK_NONE; value_seen = 1'b0;
                    head_pos = PS_LINE_LF;
                end else if (vchar(c)) begin
                    r.kind = KIND_VALUE; r.data_byte = c; r.blank_before = held_blank;
                    held_blank = BLANK_NONE; value_seen = 1'b1;
                end else if (c == CH_SP || c == CH_TAB) begin
                    // leading blanks skipped; inner run keeps its first blank
                    if (value_seen && held_blank == BLANK_NONE)
                        held_blank = (c == CH_SP) ? BLANK_SP : BLANK_TAB;
                end else bad = 1'b1;
            end
            PS_LINE_LF: if (c == CH_LF) head_pos = PS_LINE; else bad = 1'b1;
            PS_END_LF:  if (c == CH_LF) done = 1'b1; else bad = 1'b1;
            default: bad = 1'b1;
        endcase
        if (bad || done) begin
            head_status = bad ? STAT_FAIL : STAT_PASS;
            r = '0;
        end
        r.status = head_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle bound
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result-side backpressure, changed on the falling edge only.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= (no_gaps || $urandom_range(99) >= GAP_PCT) ? 1'b1 : 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted request beat, then check any result
    // beat against the oldest prediction. Results are registered, so each
    // prediction is queued before its result beat leaves.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && req_if.valid && req_if.ready)
            pending_results.push_back(step_head(req_if.byte_in, req_if.restart));
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.status       = res_if.status;
            got.kind         = res_if.kind;
            got.data_byte    = res_if.data_byte;
            got.token_end    = res_if.token_end;
            got.blank_before = res_if.blank_before;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with nothing outstanding: st=%0d kind=%0d",
                             $realtime, got.status, got.kind);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.kind !== want.kind ||
                    got.data_byte !== want.data_byte || got.token_end !== want.token_end ||
                    got.blank_before !== want.blank_before) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch exp st=%0d kind=%0d data=%02h end=%0b ",
                                  "blank=%0d, got st=%0d kind=%0d data=%02h end=%0b blank=%0d"},
                                 $realtime, want.status, want.kind, want.data_byte,
                                 want.token_end, want.blank_before, got.status, got.kind,
                                 got.data_byte, got.token_end, got.blank_before);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: one beat per call, held until accepted, then an
    // optional random gap with valid low.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.byte_in <= b;
        req_if.restart <= rs;
        do @(posedge i_clk); while (!req_if.ready);
        items_sent++;
        if (!no_gaps && $urandom_range(99) < GAP_PCT) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Sends a byte string; the first beat optionally restarts the parser.
    task automatic send_seq(input t_bytes seq, input logic rs_first);
        foreach (seq[i])
            send_byte(seq[i], (i == 0) ? rs_first : 1'b0);
    endtask

    function automatic logic [7:0] rand_tchar();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E)); while (!tchar(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_vchar();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'hFF)); while (c == CH_DEL);
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    // Well-formed head with random content: short method/target, 0..2 header
    // lines whose values may carry leading, inner and trailing blank runs.
    function automatic t_bytes build_request();
        t_bytes q;
        int     words;
        q = {};
        repeat ($urandom_range(1, 4)) q.push_back(rand_tchar());
        q.push_back(CH_SP);
        repeat ($urandom_range(1, 4)) q.push_back(rand_vchar());
        q.push_back(CH_SP);
        q = {q, CH_H, CH_T, CH_T, CH_P, CH_SLASH};
        q.push_back(8'(CH_0 + $urandom_range(9)));
        q.push_back(CH_DOT);
        q.push_back(8'(CH_0 + $urandom_range(9)));
        q = {q, CH_CR, CH_LF};
        repeat ($urandom_range(2)) begin
            repeat ($urandom_range(1, 3)) q.push_back(rand_tchar());
            q.push_back(CH_COLON);
            repeat ($urandom_range(2)) q.push_back(rand_blank());
            words = $urandom_range(2);
            for (int w = 0; w < words; w++) begin
                if (w > 0) repeat ($urandom_range(1, 3)) q.push_back(rand_blank());
                repeat ($urandom_range(1, 3)) q.push_back(rand_vchar());
            end
            repeat ($urandom_range(2)) q.push_back(rand_blank());
            q = {q, CH_CR, CH_LF};
        end
        q = {q, CH_CR, CH_LF};
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One complete head touching every token kind, both version extremes,
    // value trimming, blank collapsing with a held tab, and the pass beat.
    task automatic test_directed_request();
        t_bytes q;
        q = {8'h41, CH_SP, 8'hFF, CH_SP, CH_H, CH_T, CH_T, CH_P, CH_SLASH,
             CH_0, CH_DOT, CH_9, CH_CR, CH_LF,
             8'h7E, CH_COLON, CH_TAB, 8'h21, CH_TAB, CH_SP, 8'h80, CH_SP, CH_CR, CH_LF,
             CH_CR, CH_LF};
        send_seq(q, 1'b1);
    endtask

    // Pass and fail both stick until a restart; restart also recovers.
    task automatic test_sticky_status();
        send_byte(8'h00, 1'b0);   // after pass: still pass
        send_byte(8'h00, 1'b1);   // restart on a control byte: fail
        send_byte(8'hFF, 1'b0);   // stays failed
        send_byte(8'h47, 1'b1);   // restart into a fresh method
    endtask

    // Mostly clean heads, some with one damaged byte, some cut short by a
    // restart; a trailing byte now and then checks the held final status.
    task automatic test_random_requests(input int count);
        t_bytes q;
        int     stop_at;
        int     mode;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            q    = build_request();
            mode = $urandom_range(99);
            if (mode >= 70 && mode < 88)
                q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            else if (mode >= 88)
                q = q[0:$urandom_range(q.size() - 1)];
            send_seq(q, 1'b1);
            if ($urandom_range(3) == 0)
                send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // Raw bytes with occasional restarts.
    task automatic test_noise(input int count);
        repeat (count) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    endtask

    initial begin
        head_pos       = PS_START;
        held_blank     = BLANK_NONE;
        value_seen     = 1'b0;
        head_status    = STAT_CONT;
        mismatches     = 0;
        cycle_count    = 0;
        items_sent     = 0;
        no_gaps        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.byte_in = 8'h00;
        req_if.restart = 1'b0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_request();
        test_sticky_status();
        test_random_requests(400);
        no_gaps = 1'b1;
        test_random_requests(100);
        no_gaps = 1'b0;
        test_noise(50);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_if.sv
hw/rtl/http_request_head_parser.sv
hw/rtl/hrp_checker.sv
bench/tb_http_request_head_parser.sv
